### hw/rtl/sfr_pkg.sv
package sfr_pkg;

	// frame geometry
	localparam int unsigned FRAME_LEN = 8;
	localparam int unsigned SUM_LEN   = 7;
	localparam int unsigned COUNT_SAT = 9;

	localparam int unsigned CNT_W  = 4;
	localparam int unsigned IDX_W  = 3;
	localparam int unsigned ADDR_W = 2;

	localparam logic [7:0]        HEADER_RESET = 8'h5F;
	localparam logic [ADDR_W-1:0] ADDR_HEADER  = 2'd0;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_IDLE = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_LENGTH   = 2'd1,
		ST_HEADER   = 2'd2,
		ST_CHECKSUM = 2'd3
	} status_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] voc_level;
		logic [15:0] formaldehyde_level;
		logic [15:0] co2_level;
	} result_t;

endpackage

### hw/rtl/sfr_apb_regs.sv
module sfr_apb_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output logic [7:0]                 header_byte
);
	import sfr_pkg::*;

	logic [7:0] header_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (wr_en && paddr == ADDR_HEADER) begin
			header_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = 32'd0;
		if (paddr == ADDR_HEADER) begin
			prdata = {24'd0, header_q};
		end
	end

	assign header_byte = header_q;

endmodule

### hw/rtl/sfr_frame_acc.sv
module sfr_frame_acc (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  sfr_pkg::opcode_t op,
	input  logic [7:0]       data,
	input  logic [7:0]       header_byte,
	output sfr_pkg::result_t result
);
	import sfr_pkg::*;

	localparam logic [CNT_W-1:0] LEN_C = CNT_W'(FRAME_LEN);
	localparam logic [CNT_W-1:0] SUM_C = CNT_W'(SUM_LEN);
	localparam logic [CNT_W-1:0] SAT_C = CNT_W'(COUNT_SAT);

	logic [CNT_W-1:0] count_q;
	logic [7:0]       sum_q;
	logic [7:0]       store_q [FRAME_LEN];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
		end else if (step) begin
			if (op == OP_IDLE) begin
				count_q <= '0;
				sum_q   <= '0;
			end else begin
				if (count_q < SUM_C) begin
					sum_q <= sum_q + data;
				end
				if (count_q < SAT_C) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// store has no reset; a frame is judged only after all eight entries are written
	always_ff @(posedge clk) begin
		if (step && op == OP_BYTE && count_q < LEN_C) begin
			store_q[count_q[IDX_W-1:0]] <= data;
		end
	end

	always_comb begin
		result = '0;
		priority if (count_q != LEN_C) begin
			result.status = ST_LENGTH;
		end else if (store_q[0] != header_byte) begin
			result.status = ST_HEADER;
		end else if (store_q[FRAME_LEN-1] != sum_q) begin
			result.status = ST_CHECKSUM;
		end else begin
			result.status             = ST_OK;
			result.voc_level          = {store_q[1], store_q[2]};
			result.formaldehyde_level = {store_q[3], store_q[4]};
			result.co2_level          = {store_q[5], store_q[6]};
		end
	end

endmodule

### hw/rtl/sensor_frame_receiver_core.sv
// An idle word's result is loaded into the result register when the word leaves the input
// register; byte words give no result.
// Throughput: one word per cycle; an idle word waits in the input register only while an
// earlier result is still held and the output is stalled, and every word behind it waits too.
// Reset: asynchronous, active low; clears byte count, running sum, valids and sets
// header_byte to 0x5F. The frame store is not reset.
module sensor_frame_receiver_core (
	input  logic                       clk,
	input  logic                       arst_n,
	// input channel
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       opcode,
	input  logic [7:0]                 rx_byte,
	// result channel
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [15:0]                voc_level,
	output logic [15:0]                formaldehyde_level,
	output logic [15:0]                co2_level,
	// configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfr_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import sfr_pkg::*;

	logic       valid_s1;
	opcode_t    op_s1;
	logic [7:0] byte_s1;

	logic       out_valid_q;
	result_t    out_q;
	result_t    result;
	logic [7:0] header_byte;

	logic out_busy;   // result held and not leaving this cycle
	logic advance;    // s1 word moves through the accumulator
	logic load_out;

	sfr_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.header_byte (header_byte)
	);

	// Byte words always drain; an idle word needs a free result slot.
	assign out_busy = out_valid_q & out_stall;
	assign advance  = valid_s1 & ~(op_s1 == OP_IDLE && out_busy);
	assign load_out = advance & (op_s1 == OP_IDLE);
	assign in_stall = valid_s1 & ~advance;

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			op_s1   <= opcode_t'(opcode);
			byte_s1 <= rx_byte;
		end
	end

	// count, store, running sum and the frame check
	sfr_frame_acc u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.op          (op_s1),
		.data        (byte_s1),
		.header_byte (header_byte),
		.result      (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= result;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = out_q.status;
	assign voc_level          = out_q.voc_level;
	assign formaldehyde_level = out_q.formaldehyde_level;
	assign co2_level          = out_q.co2_level;

endmodule
